// File: src/crim_pkg.sv
package crim_pkg;

	localparam int ADDR_W         = 32;
	localparam int NUM_RANGES_DEF = 16;
	localparam int PLEN_W         = 6;
	localparam int HELD_W         = 5;
	localparam int IN_DATA_W      = 72;
	localparam int OUT_DATA_W     = 104;

	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_APPEND  = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP  = 2'd2;
	localparam logic [1:0] FUNC_REVERSE = 2'd3;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
	localparam logic [1:0] STAT_BAD_PREFIX = 2'd2;
	localparam logic [1:0] STAT_FULL       = 2'd3;

	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
		logic [ADDR_W-1:0] span;
	} crim_wr_t;

	// acc: addr plus passed spans for a lookup, passed spans for a reverse walk
	typedef struct packed {
		logic [1:0]        func;
		logic [1:0]        stat;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] pos;
		logic [ADDR_W-1:0] acc;
		logic [ADDR_W-1:0] dpos;
		logic [ADDR_W-1:0] total;
		logic [ADDR_W-1:0] idx;
		logic [ADDR_W-1:0] aval;
		logic              done;
		logic              found;
		logic              member;
	} crim_tok_t;

endpackage

// File: src/cidr_range_index_map_top.sv
// cidr range index map: ordered table of ipv4 ranges, address <-> pool index
// input beats on s_*: s_tuser carries the function (clear, append, lookup,
// reverse), s_tdata carries address, prefix length and position
// output beats on m_*: one result beat per input beat, m_tuser carries status,
// m_tdata carries flags, index, address, total size and range count
// table updates (clear, append) take effect at the accepting edge; every beat
// then sends one walk token down a row of NUM_RANGES cells, one cell per
// cycle, each cell holding one range and adding its part to the token
// a beat passes the item register, one token register in each cell and the
// output register before m_tvalid rises; no new beat is taken until its walk
// has left the cell row; only one beat is in the block at a time
// a new input beat may be taken while the previous result waits on m_tready;
// its walk starts once the output register has drained
// when the receiver stalls, m_tvalid and m_tdata hold until m_tready
// reset (arst_n low) empties the table and drops all tvalid and busy state;
// stored range words are not cleared and are only read below the range count
module cidr_range_index_map_top #(
	parameter int NUM_RANGES = crim_pkg::NUM_RANGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // address[31:0], prefix_length[37:32], position[69:38]
	input  logic [1:0]   s_tuser,   // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // index_found[0], is_member[1], index_value[33:2],
	                                // address_value[65:34], total_addresses[97:66],
	                                // ranges_held[102:98]
	output logic [1:0]   m_tuser    // status[1:0]
);
	import crim_pkg::*;

	localparam int CW = $clog2(NUM_RANGES+1);

	logic [CW-1:0]       count_q;
	logic                busy_q;
	logic                start_q;
	crim_tok_t           item_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]          m_tuser_q;

	logic                accept;
	logic [1:0]          in_func;
	logic [ADDR_W-1:0]   in_addr;
	logic [PLEN_W-1:0]   in_plen;
	logic [ADDR_W-1:0]   in_pos;
	logic [ADDR_W-1:0]   host_mask;
	logic [1:0]          app_stat;
	logic                has_room;
	crim_wr_t            wr;
	logic                inject;

	logic      valid_c [NUM_RANGES+1];
	crim_tok_t tok_c   [NUM_RANGES+1];

	crim_tok_t           fin;
	logic [1:0]          fin_stat;
	logic                fin_lookup;

	assign in_func = s_tuser;
	assign in_addr = s_tdata[31:0];
	assign in_plen = s_tdata[37:32];
	assign in_pos  = s_tdata[69:38];

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign has_room = count_q < CW'(NUM_RANGES);

	assign host_mask = ALL_ONES >> in_plen;

	always_comb begin
		if (in_plen > PLEN_W'(ADDR_W)) begin
			app_stat = STAT_BAD_PREFIX;
		end else if (!has_room) begin
			app_stat = STAT_FULL;
		end else begin
			app_stat = STAT_OK;
		end
	end

	always_comb begin
		wr.en   = accept && in_func == FUNC_APPEND && app_stat == STAT_OK;
		wr.low  = in_addr;
		wr.high = in_addr | host_mask;
		wr.span = (host_mask & ~in_addr) + ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && in_func == FUNC_CLEAR) begin
			count_q <= '0;
		end else if (wr.en) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.func   <= in_func;
			item_q.stat   <= (in_func == FUNC_APPEND) ? app_stat : STAT_OK;
			item_q.addr   <= in_addr;
			item_q.pos    <= in_pos;
			item_q.acc    <= (in_func == FUNC_LOOKUP) ? in_addr : '0;
			item_q.dpos   <= in_pos;
			item_q.total  <= '0;
			item_q.idx    <= '0;
			item_q.aval   <= '0;
			item_q.done   <= 1'b0;
			item_q.found  <= 1'b0;
			item_q.member <= 1'b0;
		end
	end

	assign inject   = start_q && !m_tvalid_q;
	assign valid_c[0] = inject;
	assign tok_c[0]   = item_q;

	for (genvar k = 0; k < NUM_RANGES; k++) begin : g_cell
		crim_cell #(
			.NUM_RANGES (NUM_RANGES),
			.IDX        (k)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.count         (count_q),
			.wr_idx        (count_q),
			.wr            (wr),
			.tok_valid_in  (valid_c[k]),
			.tok_in        (tok_c[k]),
			.tok_valid_out (valid_c[k+1]),
			.tok_out       (tok_c[k+1])
		);
	end

	assign fin        = tok_c[NUM_RANGES];
	assign fin_lookup = fin.func == FUNC_LOOKUP;

	always_comb begin
		case (fin.func)
			FUNC_CLEAR:   fin_stat = STAT_OK;
			FUNC_APPEND:  fin_stat = fin.stat;
			FUNC_LOOKUP:  fin_stat = fin.found ? STAT_OK : STAT_NOT_FOUND;
			FUNC_REVERSE: fin_stat = fin.found ? STAT_OK : STAT_NOT_FOUND;
			default:      fin_stat = STAT_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (valid_c[NUM_RANGES]) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				start_q <= 1'b1;
			end else if (inject) begin
				start_q <= 1'b0;
			end
			if (valid_c[NUM_RANGES]) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_c[NUM_RANGES]) begin
			m_tuser_q <= fin_stat;
			m_tdata_q <= {1'b0, HELD_W'(count_q), fin.total,
				(fin.func == FUNC_REVERSE) ? fin.aval : '0,
				fin_lookup ? fin.idx : '0,
				fin_lookup && fin.member,
				fin_lookup && fin.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	logic [NUM_RANGES:0] valid_vec;
	for (genvar k = 0; k <= NUM_RANGES; k++) begin : g_vv
		assign valid_vec[k] = valid_c[k];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_RANGES))
		else $error("range count above table depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec))
		else $error("more than one walk token in the cell row");

	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_c[NUM_RANGES] |-> !m_tvalid_q)
		else $error("walk result arrived while output register full");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("range count changed without an input beat");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec != '0) |-> busy_q)
		else $error("walk token in flight while block idle");
`endif

endmodule

// File: src/crim_cell.sv
module crim_cell #(
	parameter int NUM_RANGES = crim_pkg::NUM_RANGES_DEF,
	parameter int IDX        = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(NUM_RANGES+1)-1:0]    count,
	input  logic [$clog2(NUM_RANGES+1)-1:0]    wr_idx,
	input  crim_pkg::crim_wr_t                 wr,
	input  logic                               tok_valid_in,
	input  crim_pkg::crim_tok_t                tok_in,
	output logic                               tok_valid_out,
	output crim_pkg::crim_tok_t                tok_out
);
	import crim_pkg::*;

	localparam int CW = $clog2(NUM_RANGES+1);

	logic [ADDR_W-1:0] low_q;
	logic [ADDR_W-1:0] high_q;
	logic [ADDR_W-1:0] span_q;
	logic              valid_s1;
	crim_tok_t         tok_s1;
	crim_tok_t         nxt;
	logic              active;
	logic              in_rng;
	logic [ADDR_W-1:0] rsum;

	assign active = CW'(IDX) < count;

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == CW'(IDX)) begin
			low_q  <= wr.low;
			high_q <= wr.high;
			span_q <= wr.span;
		end
	end

	always_comb begin
		nxt    = tok_in;
		in_rng = (tok_in.addr >= low_q) && (tok_in.addr <= high_q);
		rsum   = tok_in.acc + span_q;
		if (active) begin
			nxt.total = tok_in.total + span_q;
			if (in_rng) begin
				nxt.member = 1'b1;
			end
			if (!tok_in.done) begin
				case (tok_in.func)
					FUNC_LOOKUP: begin
						if (in_rng) begin
							nxt.found = 1'b1;
							nxt.idx   = tok_in.acc - low_q;
							nxt.done  = 1'b1;
						end else if (tok_in.addr > high_q) begin
							nxt.acc = rsum;
						end else begin
							nxt.done = 1'b1;
						end
					end
					FUNC_REVERSE: begin
						if (tok_in.pos < rsum) begin
							nxt.aval  = low_q + tok_in.dpos;
							nxt.found = 1'b1;
							nxt.done  = 1'b1;
						end else begin
							nxt.acc  = rsum;
							nxt.dpos = tok_in.dpos - span_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid_in) begin
			tok_s1 <= nxt;
		end
	end

	assign tok_valid_out = valid_s1;
	assign tok_out       = tok_s1;

endmodule
